// File: src/aais_pkg.sv
// ----------------------------------------------------------------------------
// aais_pkg
// Shared types, constants and the coverage helper of the area-average scaler.
// ----------------------------------------------------------------------------
`default_nettype none
package aais_pkg;

  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 512;

  localparam int unsigned CfgW   = 10;
  localparam int unsigned FracW  = 16;
  localparam int unsigned RatioW = CfgW + FracW;
  localparam int unsigned PosW   = 9;
  localparam int unsigned ChW    = 8;
  localparam int unsigned StepW  = 5;
  localparam int unsigned PixW   = 20;
  localparam int unsigned FxW    = PosW + RatioW + 1;
  localparam int unsigned CovW   = FracW + 1;
  localparam int unsigned AddrW  = 4;

  typedef enum logic {
    OpStore   = 1'b0,
    OpCompute = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RegSrcW = 2'd0,
    RegSrcH = 2'd1,
    RegTgtW = 2'd2,
    RegTgtH = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            opcode;
    logic [PosW-1:0] x_pos;
    logic [PosW-1:0] y_pos;
    logic [ChW-1:0]  alpha_in;
    logic [ChW-1:0]  red_in;
    logic [ChW-1:0]  green_in;
    logic [ChW-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] alpha_out;
    logic [ChW-1:0] red_out;
    logic [ChW-1:0] green_out;
    logic [ChW-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] source_width;
    logic [CfgW-1:0] source_height;
    logic [CfgW-1:0] target_width;
    logic [CfgW-1:0] target_height;
  } cfg_t;

  function automatic logic [CovW-1:0] coverage(logic [FxW-1:0] lo, logic [FxW-1:0] hi,
                                                logic [PixW-1:0] pix);
    logic [FxW:0] a;
    logic [FxW:0] b;
    logic [FxW:0] s;
    logic [FxW:0] e;
    logic [FxW:0] d;
    a = {1'b0, pix, {FracW{1'b0}}};
    b = a + (FxW+1)'(1 << FracW);
    s = ({1'b0, lo} > a) ? {1'b0, lo} : a;
    e = ({1'b0, hi} < b) ? {1'b0, hi} : b;
    d = e - s;
    coverage = (e > s) ? d[CovW-1:0] : '0;
  endfunction

endpackage
`default_nettype wire

// File: src/aais_cfg.sv
// ----------------------------------------------------------------------------
// aais_cfg
// APB register file holding source and target image sizes.
// ----------------------------------------------------------------------------
`default_nettype none
module aais_cfg
  import aais_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= CfgW'(512);
      cfg_q.source_height <= CfgW'(512);
      cfg_q.target_width  <= CfgW'(512);
      cfg_q.target_height <= CfgW'(512);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegSrcW: cfg_q.source_width  <= pwdata[CfgW-1:0];
        RegSrcH: cfg_q.source_height <= pwdata[CfgW-1:0];
        RegTgtW: cfg_q.target_width  <= pwdata[CfgW-1:0];
        RegTgtH: cfg_q.target_height <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSrcW: prdata = {{(32-CfgW){1'b0}}, cfg_q.source_width};
      RegSrcH: prdata = {{(32-CfgW){1'b0}}, cfg_q.source_height};
      RegTgtW: prdata = {{(32-CfgW){1'b0}}, cfg_q.target_width};
      RegTgtH: prdata = {{(32-CfgW){1'b0}}, cfg_q.target_height};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/aais_div.sv
// ----------------------------------------------------------------------------
// aais_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module aais_div
  import aais_pkg::*;
#(
  parameter int unsigned RW = 51
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RW-1:0]     den_i,
  input  wire logic [RW-1:0]     rem_i,
  input  wire logic [RatioW-1:0] bits_i,
  input  wire logic [StepW-1:0]  steps_i,
  output logic                   done_o,
  output logic      [RatioW-1:0] quot_o
);

  logic              active_q;
  logic              done_q;
  logic [StepW-1:0]  cnt_q;
  logic [RW-1:0]     den_q;
  logic [RW-1:0]     rem_q;
  logic [RatioW-1:0] bits_q;
  logic [RatioW-1:0] quot_q;
  logic [RW:0]       trial;
  logic [RW:0]       diff;
  logic              ge;

  assign trial  = {rem_q, bits_q[RatioW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= steps_i;
      end else if (active_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= rem_i;
      bits_q <= bits_i;
      quot_q <= '0;
    end else if (active_q) begin
      rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      bits_q <= {bits_q[RatioW-2:0], 1'b0};
      quot_q <= {quot_q[RatioW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: src/area_average_image_scaler.sv
// ----------------------------------------------------------------------------
// area_average_image_scaler
// Area-average resampler answering single destination pixel requests.
// ----------------------------------------------------------------------------
// Store: busy stays low. Compute: the two ratio divisions and window setup,
// then each covered source pixel, with a row step per source row, passes
// through the pixel memory and multipliers, then four channel divisions in
// the shared divider (skipped, result zero, when the area is zero); result strobe lasts
// one cycle, receiver cannot stall.
// Reset clears control and loads size registers to 512; pixel memory is not
// cleared.
`default_nettype none
module area_average_image_scaler
  import aais_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         item_i,
  output logic                  res_valid_o,
  output out_item_t             res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned MemAw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned AreaW = 2 * CovW + 1 + $clog2(MAX_WIDTH + 1)
                                  + $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SumW  = AreaW + ChW;
  localparam int unsigned NumW  = SumW + 2;
  localparam int unsigned DivRw = AreaW + 1;
  localparam int unsigned PaW   = 2 * CovW;
  localparam int unsigned ProdW = PaW + ChW;

  typedef enum logic [3:0] {
    SIdle, SRx, SRxW, SRy, SRyW, SWin, SBnd, SRow, SPix, SPa, SProd, SAcc,
    SDiv, SDivW, SOut
  } state_e;

  cfg_t cfg;

  aais_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  state_e            state_q;
  logic [PosW-1:0]   x_q, y_q;
  logic [RatioW-1:0] rx_q, ry_q;
  logic [FxW-1:0]    x0_q, x1_q, y0_q, y1_q;
  logic [PixW-1:0]   xb_q, xe_q, ye_q, sx_q, sy_q;
  logic [CovW-1:0]   covx_q, covy_q;
  logic [PaW-1:0]    pa_q;
  logic [ProdW-1:0]  prod_q [4];
  logic [AreaW-1:0]  area_q;
  logic [SumW-1:0]   sum_q [4];
  logic [1:0]        ch_q;
  out_item_t         res_q;
  logic [31:0]       rdata_q;
  logic [31:0]       mem [Depth];

  logic              div_start, div_done;
  logic [DivRw-1:0]  div_den, div_rem;
  logic [RatioW-1:0] div_bits, div_quot;
  logic [StepW-1:0]  div_steps;
  logic [NumW-1:0]   num;
  logic [NumW-1:0]   num_sh;
  logic [PixW-1:0]   sw, sh;
  logic [FxW-1:0]   x1, y1;
  logic [FxW:0]     xc, yc;
  logic [PixW:0]    xe_r, ye_r;
  logic             acc_go;
  logic [MemAw-1:0] rd_addr, wr_addr;
  logic             wr_en;

  assign busy        = (state_q != SIdle);
  assign acc_go      = start && !busy;
  assign res_valid_o = (state_q == SOut);
  assign res_o       = res_q;

  assign sw = (32'(cfg.source_width) > MAX_WIDTH) ? PixW'(MAX_WIDTH)
                                                  : PixW'(cfg.source_width);
  assign sh = (32'(cfg.source_height) > MAX_HEIGHT) ? PixW'(MAX_HEIGHT)
                                                    : PixW'(cfg.source_height);

  assign x1   = x0_q + FxW'(rx_q);
  assign y1   = y0_q + FxW'(ry_q);
  assign xc   = {1'b0, x1} + (FxW+1)'((1 << FracW) - 1);
  assign yc   = {1'b0, y1} + (FxW+1)'((1 << FracW) - 1);
  assign xe_r = xc[FxW:FracW];
  assign ye_r = yc[FxW:FracW];

  assign num    = {sum_q[ch_q], 1'b0} + NumW'(area_q);
  assign num_sh = num >> ChW;

  always_comb begin
    div_start = 1'b0;
    div_den   = '0;
    div_rem   = '0;
    div_bits  = '0;
    div_steps = StepW'(RatioW);
    unique case (state_q)
      SRx: begin
        div_start = 1'b1;
        div_den   = DivRw'(cfg.target_width);
        div_bits  = {cfg.source_width, {FracW{1'b0}}};
      end
      SRy: begin
        div_start = 1'b1;
        div_den   = DivRw'(cfg.target_height);
        div_bits  = {cfg.source_height, {FracW{1'b0}}};
      end
      SDiv: begin
        div_start = (area_q != '0);
        div_den   = {area_q, 1'b0};
        div_rem   = num_sh[DivRw-1:0];
        div_bits  = {num[ChW-1:0], {(RatioW-ChW){1'b0}}};
        div_steps = StepW'(ChW);
      end
      default: ;
    endcase
  end

  aais_div #(
    .RW (DivRw)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .den_i   (div_den),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign rd_addr = MemAw'(MemAw'(sy_q) * MemAw'(MAX_WIDTH) + MemAw'(sx_q));
  assign wr_addr = MemAw'(MemAw'(item_i.y_pos) * MemAw'(MAX_WIDTH) + MemAw'(item_i.x_pos));
  assign wr_en   = acc_go && (op_e'(item_i.opcode) == OpStore)
                   && (32'(item_i.x_pos) < MAX_WIDTH) && (32'(item_i.y_pos) < MAX_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {item_i.alpha_in, item_i.red_in, item_i.green_in, item_i.blue_in};
    end
    if (state_q == SPix) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ch_q    <= '0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (acc_go && (op_e'(item_i.opcode) == OpCompute)) begin
            x_q     <= item_i.x_pos;
            y_q     <= item_i.y_pos;
            state_q <= SRx;
          end
        end
        SRx: state_q <= SRxW;
        SRxW: begin
          if (div_done) begin
            rx_q    <= (cfg.target_width == '0) ? '0 : div_quot;
            state_q <= SRy;
          end
        end
        SRy: state_q <= SRyW;
        SRyW: begin
          if (div_done) begin
            ry_q    <= (cfg.target_height == '0) ? '0 : div_quot;
            state_q <= SWin;
          end
        end
        SWin: begin
          x0_q    <= FxW'((PosW+RatioW)'(x_q) * rx_q);
          y0_q    <= FxW'((PosW+RatioW)'(y_q) * ry_q);
          area_q  <= '0;
          for (int c = 0; c < 4; c++) sum_q[c] <= '0;
          state_q <= SBnd;
        end
        SBnd: begin
          x1_q <= x1;
          y1_q <= y1;
          xb_q <= x0_q[FxW-1:FracW];
          sy_q <= y0_q[FxW-1:FracW];
          xe_q <= (xe_r > {1'b0, sw}) ? sw : xe_r[PixW-1:0];
          ye_q <= (ye_r > {1'b0, sh}) ? sh : ye_r[PixW-1:0];
          ch_q <= '0;
          if (({1'b0, x0_q[FxW-1:FracW]} >= xe_r) || (x0_q[FxW-1:FracW] >= sw)
              || ({1'b0, y0_q[FxW-1:FracW]} >= ye_r) || (y0_q[FxW-1:FracW] >= sh)) begin
            state_q <= SDiv;
          end else begin
            state_q <= SRow;
          end
        end
        SRow: begin
          covy_q  <= coverage(y0_q, y1_q, sy_q);
          sx_q    <= xb_q;
          state_q <= SPix;
        end
        SPix: begin
          covx_q  <= coverage(x0_q, x1_q, sx_q);
          state_q <= SPa;
        end
        SPa: begin
          pa_q    <= covx_q * covy_q;
          state_q <= SProd;
        end
        SProd: begin
          for (int c = 0; c < 4; c++) begin
            prod_q[c] <= pa_q * rdata_q[8*(3-c) +: 8];
          end
          state_q <= SAcc;
        end
        SAcc: begin
          area_q <= area_q + AreaW'(pa_q);
          for (int c = 0; c < 4; c++) sum_q[c] <= sum_q[c] + SumW'(prod_q[c]);
          if (sx_q + PixW'(1) < xe_q) begin
            sx_q    <= sx_q + PixW'(1);
            state_q <= SPix;
          end else if (sy_q + PixW'(1) < ye_q) begin
            sy_q    <= sy_q + PixW'(1);
            state_q <= SRow;
          end else begin
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (area_q == '0) begin
            res_q   <= '0;
            state_q <= SOut;
          end else begin
            state_q <= SDivW;
          end
        end
        SDivW: begin
          if (div_done) begin
            case (ch_q)
              2'd0:    res_q.alpha_out <= div_quot[ChW-1:0];
              2'd1:    res_q.red_out   <= div_quot[ChW-1:0];
              2'd2:    res_q.green_out <= div_quot[ChW-1:0];
              default: res_q.blue_out  <= div_quot[ChW-1:0];
            endcase
            ch_q    <= ch_q + 2'd1;
            state_q <= (ch_q == 2'd3) ? SOut : SDiv;
          end
        end
        SOut: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
`default_nettype wire
